>>> rtl/bitmap_first_fit_block_allocator_macros.svh
`ifndef BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BFFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bffa check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define BFFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bffa check failed");

`endif

>>> rtl/bffa_pkg.sv
package bffa_pkg;

  localparam int unsigned MAX_BLOCKS_DEF  = 1024;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned WORD_BITS       = 5;
  localparam int unsigned RUN_W           = WORD_BITS + 1;
  localparam int unsigned CNT_W           = 11;
  localparam int unsigned IDX_W           = 10;
  localparam int unsigned BLOCK_COUNT_RST = 1024;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] best;
  } scan_status_t;

endpackage

>>> rtl/bffa_map_ram.sv
module bffa_map_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5,
  parameter int unsigned W     = 32
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [W-1:0]  wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [W-1:0]  rd_data_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/bffa_run_scan.sv
module bffa_run_scan #(
  parameter int unsigned AW = 5,
  parameter int unsigned PW = AW + bffa_pkg::WORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clr_i,
  input  logic                         word_vld_i,
  input  logic [bffa_pkg::WORD_W-1:0]  used_i,
  input  logic [AW-1:0]                word_addr_i,
  input  logic [bffa_pkg::CNT_W-1:0]   count_i,
  output logic                         idle_o,
  output bffa_pkg::scan_status_t       status_o,
  output logic [PW-1:0]                end_pos_o
);

  import bffa_pkg::*;

  typedef logic [WORD_W-1:0][RUN_W-1:0] runs_t;

  // free run length ending at each bit, by doubling
  function automatic runs_t trail_runs(input logic [WORD_W-1:0] free_w);
    runs_t            r;
    runs_t            nx;
    logic [RUN_W-1:0] step;
    int               s;
    for (int j = 0; j < WORD_W; j++) begin
      r[j] = RUN_W'(free_w[j]);
    end
    for (int k = 0; k < WORD_BITS; k++) begin
      s    = 1 << k;
      step = RUN_W'(s);
      nx   = r;
      for (int j = 0; j < WORD_W; j++) begin
        if (j >= s && r[j] == step) begin
          nx[j] = step + r[(j >= s) ? (j - s) : j];
        end
      end
      r = nx;
    end
    return r;
  endfunction

  function automatic logic [RUN_W-1:0] lead_free(input logic [WORD_W-1:0] free_w);
    logic [WORD_W-1:0] rev;
    runs_t             t;
    for (int j = 0; j < WORD_W; j++) begin
      rev[j] = free_w[WORD_W-1-j];
    end
    t = trail_runs(rev);
    return t[WORD_W-1];
  endfunction

  function automatic logic [RUN_W-1:0] max_run(input runs_t r);
    runs_t t;
    t = r;
    for (int s = WORD_W / 2; s >= 1; s = s >> 1) begin
      for (int j = 0; j < s; j++) begin
        t[j] = (t[2*j] > t[2*j+1]) ? t[2*j] : t[2*j+1];
      end
    end
    return t[0];
  endfunction

  logic                         s1_vld_q;
  runs_t                        lq_q;
  logic [RUN_W-1:0]             lead_q;
  logic [AW-1:0]                addr_q;

  logic [CNT_W-1:0]             run_q, run_d;
  logic [CNT_W-1:0]             best_q, best_d;
  logic                         found_q, found_d;
  logic [PW-1:0]                end_q, end_d;

  logic [WORD_W-1:0][CNT_W-1:0] run_at;
  logic [WORD_W-1:0]            hit;
  logic [WORD_W-1:0]            hit_low;
  logic [WORD_BITS-1:0]         hit_idx;
  logic [CNT_W-1:0]             lead_run;
  logic [CNT_W-1:0]             inner_max;
  logic [CNT_W-1:0]             word_best;

  always_ff @(posedge clk_i) begin
    if (word_vld_i) begin
      lq_q   <= trail_runs(~used_i);
      lead_q <= lead_free(~used_i);
      addr_q <= word_addr_i;
    end
  end

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      run_at[j] = (lq_q[j] == RUN_W'(j + 1)) ? CNT_W'(run_q + CNT_W'(j + 1))
                                              : CNT_W'(lq_q[j]);
      hit[j]    = (count_i != '0) && (run_at[j] == count_i);
    end
    hit_low = hit & (~hit + WORD_W'(1));
    hit_idx = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (hit_low[j]) begin
        hit_idx = hit_idx | WORD_BITS'(j);
      end
    end
    lead_run  = CNT_W'(run_q + CNT_W'(lead_q));
    inner_max = CNT_W'(max_run(lq_q));
    word_best = (inner_max > lead_run) ? inner_max : lead_run;

    run_d   = run_q;
    best_d  = best_q;
    found_d = found_q;
    end_d   = end_q;
    if (clr_i) begin
      run_d   = '0;
      best_d  = '0;
      found_d = 1'b0;
    end else if (s1_vld_q) begin
      run_d  = (lq_q[WORD_W-1] == RUN_W'(WORD_W)) ? CNT_W'(run_q + CNT_W'(WORD_W))
                                                  : CNT_W'(lq_q[WORD_W-1]);
      best_d = (word_best > best_q) ? word_best : best_q;
      if (!found_q && (hit != '0)) begin
        found_d = 1'b1;
        end_d   = {addr_q, hit_idx};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      run_q    <= '0;
      best_q   <= '0;
      found_q  <= 1'b0;
    end else begin
      s1_vld_q <= word_vld_i;
      run_q    <= run_d;
      best_q   <= best_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q <= end_d;
  end

  assign idle_o          = !s1_vld_q;
  assign status_o.found  = found_q;
  assign status_o.best   = best_q;
  assign end_pos_o       = end_q;

endmodule

>>> rtl/bitmap_first_fit_block_allocator.sv
// Each pass reads L = ceil(managed blocks / 32) words, at least 1. A free or a failed
// allocate is one pass; a success is a find pass, then a mark and rescan pass.
// One request at a time; the map memory streams one 32-bit word per cycle.
// done_o pulses for one cycle with the result; the receiver cannot stall.
// Reset sweeps every map word to free with busy high;
// block count resets to 1024, longest free run to the managed count.
module bitmap_first_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS = bffa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       command_i,
  input  logic [bffa_pkg::CNT_W-1:0] count_i,
  input  logic [bffa_pkg::IDX_W-1:0] first_block_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bffa_pkg::CNT_W-1:0] cfg_data_i,
  output logic                       done_o,
  output logic                       success_o,
  output logic [bffa_pkg::IDX_W-1:0] run_start_o,
  output logic [bffa_pkg::CNT_W-1:0] longest_free_o
);

  import bffa_pkg::*;

  localparam int unsigned NW = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW = (NW > 1) ? $clog2(NW) : 1;
  localparam int unsigned PW = AW + WORD_BITS;
  localparam int unsigned BW = (PW > CNT_W + 1) ? PW : CNT_W + 1;
  localparam logic [AW-1:0]    LAST_ADDR   = AW'(NW - 1);
  localparam logic [CNT_W-1:0] LONGEST_RST = (MAX_BLOCKS < BLOCK_COUNT_RST) ?
                                             CNT_W'(MAX_BLOCKS) : CNT_W'(BLOCK_COUNT_RST);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_ISSUE = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_e;

  typedef enum logic [1:0] {
    PASS_FIND = 2'd0,
    PASS_MARK = 2'd1,
    PASS_FREE = 2'd2
  } pass_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  state_e             state_q, state_d;
  pass_e              pass_q, pass_d;
  logic [AW-1:0]      wcnt_q, wcnt_d;
  logic [AW-1:0]      last_q, last_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [BW-1:0]      lo_q, lo_d;
  logic [BW-1:0]      hi_q, hi_d;
  logic [IDX_W-1:0]   start_q, start_d;
  logic [CNT_W-1:0]   block_count_q;
  logic [CNT_W-1:0]   longest_q, longest_d;
  logic               done_q, done_d;
  logic               success_q, success_d;
  logic [IDX_W-1:0]   run_start_q, run_start_d;
  logic               rd_vld_q;
  logic [AW-1:0]      rd_addr_q;

  logic [CNT_W-1:0]          n_blocks;
  logic [AW-1:0]             last_word;
  logic                      ram_rd_en;
  logic                      ram_wr_en;
  logic [AW-1:0]             ram_wr_addr;
  logic [WORD_W-1:0]         ram_wr_data;
  logic [WORD_W-1:0]         ram_rd_data;
  logic [WORD_W-1:0][BW-1:0] bit_pos;
  logic [WORD_W-1:0]         in_n;
  logic [WORD_W-1:0]         in_rng;
  logic [WORD_W-1:0]         new_word;
  logic [WORD_W-1:0]         scan_used;
  logic                      scan_clr;
  logic                      scan_idle;
  scan_status_t              scan_status;
  logic [PW-1:0]             scan_end;
  logic [BW-1:0]             mark_lo;

  assign n_blocks  = (32'(block_count_q) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : block_count_q;
  assign last_word = (n_blocks == '0) ? '0 : AW'((n_blocks - CNT_W'(1)) >> WORD_BITS);
  assign mark_lo   = BW'(scan_end) - BW'(count_q) + BW'(1);

  bffa_map_ram #(
    .DEPTH (NW),
    .AW    (AW),
    .W     (WORD_W)
  ) u_map (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (wcnt_q),
    .rd_data_o (ram_rd_data)
  );

  bffa_run_scan #(
    .AW (AW),
    .PW (PW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (scan_clr),
    .word_vld_i  (rd_vld_q),
    .used_i      (scan_used),
    .word_addr_i (rd_addr_q),
    .count_i     (count_q),
    .idle_o      (scan_idle),
    .status_o    (scan_status),
    .end_pos_o   (scan_end)
  );

  // modify the word read back and drive the write port
  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      bit_pos[j] = BW'({rd_addr_q, WORD_BITS'(j)});
      in_n[j]    = bit_pos[j] < BW'(n_blocks);
      in_rng[j]  = in_n[j] && (bit_pos[j] >= lo_q) && (bit_pos[j] < hi_q);
    end
    unique case (pass_q)
      PASS_MARK: new_word = ram_rd_data | in_rng;
      PASS_FREE: new_word = ram_rd_data & ~in_rng;
      default:   new_word = ram_rd_data;
    endcase
    scan_used = new_word | ~in_n;

    ram_rd_en = (state_q == ST_ISSUE);
    if (state_q == ST_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = wcnt_q;
      ram_wr_data = '0;
    end else begin
      ram_wr_en   = rd_vld_q && (pass_q != PASS_FIND);
      ram_wr_addr = rd_addr_q;
      ram_wr_data = new_word;
    end
  end

  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    wcnt_d      = wcnt_q;
    last_d      = last_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    start_d     = start_q;
    longest_d   = longest_q;
    done_d      = 1'b0;
    success_d   = success_q;
    run_start_d = run_start_q;
    scan_clr    = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        wcnt_d = AW'(wcnt_q + AW'(1));
        if (wcnt_q == LAST_ADDR) begin
          wcnt_d  = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          count_d  = count_i;
          wcnt_d   = '0;
          last_d   = last_word;
          scan_clr = 1'b1;
          state_d  = ST_ISSUE;
          if (cmd_e'(command_i) == CMD_FREE) begin
            pass_d = PASS_FREE;
            lo_d   = BW'(first_block_i);
            hi_d   = BW'(first_block_i) + BW'(count_i);
          end else begin
            pass_d = PASS_FIND;
          end
        end
      end
      ST_ISSUE: begin
        if (wcnt_q == last_q) begin
          state_d = ST_DRAIN;
        end else begin
          wcnt_d = AW'(wcnt_q + AW'(1));
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && scan_idle) begin
          state_d = ST_IDLE;
          unique case (pass_q)
            PASS_FIND: begin
              if (scan_status.found) begin
                pass_d   = PASS_MARK;
                lo_d     = mark_lo;
                hi_d     = BW'(scan_end) + BW'(1);
                start_d  = IDX_W'(mark_lo);
                wcnt_d   = '0;
                scan_clr = 1'b1;
                state_d  = ST_ISSUE;
              end else begin
                done_d      = 1'b1;
                success_d   = 1'b0;
                run_start_d = '0;
                longest_d   = scan_status.best;
              end
            end
            PASS_MARK: begin
              done_d      = 1'b1;
              success_d   = 1'b1;
              run_start_d = start_q;
              longest_d   = scan_status.best;
            end
            PASS_FREE: begin
              done_d      = 1'b1;
              success_d   = 1'b1;
              run_start_d = '0;
            end
            default: ;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      pass_q        <= PASS_FIND;
      wcnt_q        <= '0;
      last_q        <= '0;
      block_count_q <= CNT_W'(BLOCK_COUNT_RST);
      longest_q     <= LONGEST_RST;
      done_q        <= 1'b0;
      rd_vld_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      pass_q    <= pass_d;
      wcnt_q    <= wcnt_d;
      last_q    <= last_d;
      longest_q <= longest_d;
      done_q    <= done_d;
      rd_vld_q  <= ram_rd_en;
      if (cfg_valid_i && cfg_ready_o) begin
        block_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    count_q     <= count_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    start_q     <= start_d;
    success_q   <= success_d;
    run_start_q <= run_start_d;
    rd_addr_q   <= wcnt_q;
  end

  assign busy           = (state_q != ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign done_o         = done_q;
  assign success_o      = success_q;
  assign run_start_o    = run_start_q;
  assign longest_free_o = longest_q;

endmodule

>>> rtl/bffa_checker.sv
`include "bitmap_first_fit_block_allocator_macros.svh"

module bffa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       done_o,
  input logic                       success_o,
  input logic [bffa_pkg::IDX_W-1:0] run_start_o
);

  `BFFA_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy)
  `BFFA_ASSERT_NEXT(a_no_instant_result, start && !busy, !done_o)
  `BFFA_ASSERT_NOW(a_result_when_idle, done_o, !busy)
  `BFFA_ASSERT_NEXT(a_single_result, done_o, !done_o)
  `BFFA_ASSERT_NOW(a_fail_start_zero, done_o && !success_o, run_start_o == '0)

endmodule

bind bitmap_first_fit_block_allocator bffa_checker u_bffa_checker (.*);

>>> bench/bffa_alloc_checker.sv
package bffa_test_pkg;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } bffa_cmd_e;

endpackage

module bffa_alloc_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       command_i,
  input  logic [bffa_pkg::CNT_W-1:0] count_i,
  input  logic [bffa_pkg::IDX_W-1:0] first_block_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_o,
  input  logic [bffa_pkg::CNT_W-1:0] cfg_data_i,
  input  logic                       done_o,
  input  logic                       success_o,
  input  logic [bffa_pkg::IDX_W-1:0] run_start_o,
  input  logic [bffa_pkg::CNT_W-1:0] longest_free_o,
  output int                         fail_count_o,
  output int                         outstanding_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import bffa_pkg::*;
  import bffa_test_pkg::*;

  localparam int MAP_SIZE = MAX_BLOCKS_DEF;

  typedef struct packed {
    logic             success;
    logic [IDX_W-1:0] run_start;
    logic [CNT_W-1:0] longest_free;
  } alloc_reply_t;

  logic [MAP_SIZE-1:0] used_blocks;
  logic [CNT_W-1:0]    block_limit;
  logic [CNT_W-1:0]    longest_run;
  alloc_reply_t        expected_replies[$];
  int                  mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic alloc_reply_t serve_command(input bffa_cmd_e cmd,
                                                 input logic [CNT_W-1:0] cnt,
                                                 input logic [IDX_W-1:0] first);
    int           n;
    int           run_from;
    int           run_len;
    int           best;
    bit           found;
    alloc_reply_t reply;
    n = (int'(block_limit) > MAP_SIZE) ? MAP_SIZE : int'(block_limit);
    reply = '0;
    found = 1'b0;
    run_from = 0;
    run_len = 0;
    if (cmd == CMD_ALLOC) begin
      for (int i = 0; i < n && !found; i++) begin
        if (used_blocks[i]) begin
          run_from = i + 1;
          run_len = 0;
        end else begin
          run_len++;
          if (run_len == int'(cnt)) found = 1'b1;
        end
      end
      if (found) begin
        for (int k = 0; k < run_len; k++) used_blocks[run_from + k] = 1'b1;
        reply.success = 1'b1;
        reply.run_start = run_from[IDX_W-1:0];
      end
      best = 0;
      run_len = 0;
      for (int i = 0; i < n; i++) begin
        if (used_blocks[i]) begin
          if (run_len > best) best = run_len;
          run_len = 0;
        end else begin
          run_len++;
        end
      end
      if (run_len > best) best = run_len;
      longest_run = best[CNT_W-1:0];
    end else begin
      for (int i = 0; i < int'(cnt); i++) begin
        if (int'(first) + i < n) used_blocks[int'(first) + i] = 1'b0;
      end
      reply.success = 1'b1;
    end
    reply.longest_free = longest_run;
    return reply;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_reply_t want;
    if (!rst_ni) begin
      used_blocks = '0;
      block_limit = CNT_W'(BLOCK_COUNT_RST);
      longest_run = (BLOCK_COUNT_RST > MAP_SIZE) ? CNT_W'(MAP_SIZE) : CNT_W'(BLOCK_COUNT_RST);
      expected_replies.delete();
      outstanding_o <= 0;
    end else begin
      if (done_o) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("result strobe with no request outstanding");
        end else begin
          want = expected_replies.pop_front();
          if (success_o !== want.success)
            report_mismatch($sformatf("success got %0b, expected %0b",
                                      success_o, want.success));
          if (run_start_o !== want.run_start)
            report_mismatch($sformatf("run_start got %0d, expected %0d",
                                      run_start_o, want.run_start));
          if (longest_free_o !== want.longest_free)
            report_mismatch($sformatf("longest_free got %0d, expected %0d",
                                      longest_free_o, want.longest_free));
        end
      end
      if (cfg_valid_i && cfg_ready_o) block_limit = cfg_data_i;
      if (start && !busy)
        expected_replies.push_back(serve_command(bffa_cmd_e'(command_i), count_i,
                                                 first_block_i));
      outstanding_o <= expected_replies.size();
    end
  end

endmodule

>>> bench/bitmap_first_fit_block_allocator_test.sv
module bitmap_first_fit_block_allocator_test;

  timeunit 1ns;
  timeprecision 1ps;

  import bffa_pkg::*;
  import bffa_test_pkg::*;

  localparam int SETTLE_CYCLES   = 80;
  localparam int STALL_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 106;
  localparam int NUM_PHASES      = 12;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic             command_i;
  logic [CNT_W-1:0] count_i;
  logic [IDX_W-1:0] first_block_i;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CNT_W-1:0] cfg_data_i;
  logic             done_o;
  logic             success_o;
  logic [IDX_W-1:0] run_start_o;
  logic [CNT_W-1:0] longest_free_o;
  int               fail_count;
  int               outstanding;
  int               idle_cycles = 0;

  bitmap_first_fit_block_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .count_i        (count_i),
    .first_block_i  (first_block_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .success_o      (success_o),
    .run_start_o    (run_start_o),
    .longest_free_o (longest_free_o)
  );

  bffa_alloc_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .count_i        (count_i),
    .first_block_i  (first_block_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .success_o      (success_o),
    .run_start_o    (run_start_o),
    .longest_free_o (longest_free_o),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send(input bffa_cmd_e cmd, input logic [CNT_W-1:0] cnt,
                      input logic [IDX_W-1:0] first);
    start         <= 1'b1;
    command_i     <= cmd;
    count_i       <= cnt;
    first_block_i <= first;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_block_count(input logic [CNT_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_request(input int managed);
    int               pick;
    int               top_idx;
    logic [CNT_W-1:0] cnt;
    logic [IDX_W-1:0] first;
    top_idx = (managed > 0) ? managed - 1 : 0;
    pick = $urandom_range(0, 99);
    first = IDX_W'($urandom_range(0, 1023));
    if ($urandom_range(0, 99) < 60) begin
      if (pick < 5) cnt = '0;
      else if (pick < 75) cnt = CNT_W'($urandom_range(1, 8));
      else if (pick < 90) cnt = CNT_W'($urandom_range(9, 64));
      else if (pick < 97) cnt = CNT_W'($urandom_range(1, managed + 2));
      else cnt = CNT_W'($urandom_range(1024, 2047));
      send(CMD_ALLOC, cnt, first);
    end else begin
      if ($urandom_range(0, 99) < 80) first = IDX_W'($urandom_range(0, top_idx));
      if (pick < 70) cnt = CNT_W'($urandom_range(1, 16));
      else if (pick < 90) cnt = CNT_W'($urandom_range(17, 256));
      else if (pick < 98) cnt = '0;
      else cnt = CNT_W'($urandom_range(1024, 2047));
      send(CMD_FREE, cnt, first);
    end
  endtask

  initial begin
    logic [CNT_W-1:0] phase_counts[NUM_PHASES];
    int               managed;
    int               burst_left;
    int               gap;
    phase_counts = '{11'd0, 11'd1, 11'd2047, 11'd8, 11'd37, 11'd1024,
                     11'd100, 11'd200, 11'd64, 11'd1000, 11'd3, 11'd500};
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    command_i     <= 1'b0;
    count_i       <= '0;
    first_block_i <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(CMD_ALLOC, 11'd0, 10'd0);
    send(CMD_ALLOC, 11'd1, 10'd0);
    send(CMD_ALLOC, 11'd1024, 10'd0);
    send(CMD_FREE, 11'd1, 10'd0);
    send(CMD_ALLOC, 11'd1024, 10'd0);
    send(CMD_ALLOC, 11'd1, 10'd0);
    send(CMD_FREE, 11'd2047, 10'd1000);
    send(CMD_ALLOC, 11'd2047, 10'd0);
    send(CMD_ALLOC, 11'd24, 10'd0);
    send(CMD_FREE, 11'd1024, 10'd0);
    send(CMD_ALLOC, 11'd5, 10'd1023);
    send(CMD_ALLOC, 11'd3, 10'd0);
    send(CMD_FREE, 11'd2, 10'd2);
    send(CMD_ALLOC, 11'd2, 10'd0);
    send(CMD_FREE, 11'd0, 10'd5);
    send(CMD_ALLOC, 11'd1, 10'd0);
    send(CMD_FREE, 11'd1, 10'd1023);
    send(CMD_ALLOC, 11'd1016, 10'd0);
    send(CMD_FREE, 11'd2047, 10'd1023);
    send(CMD_ALLOC, 11'd1, 10'd0);
    send(CMD_FREE, 11'd1024, 10'd0);

    burst_left = 0;
    foreach (phase_counts[p]) begin
      write_block_count(phase_counts[p]);
      managed = (int'(phase_counts[p]) > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF
                                                         : int'(phase_counts[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i == ITEMS_PER_PHASE / 2) drain();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
        random_request(managed);
        burst_left--;
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/bffa_pkg.sv
rtl/bffa_map_ram.sv
rtl/bffa_run_scan.sv
rtl/bitmap_first_fit_block_allocator.sv
rtl/bffa_checker.sv
bench/bffa_alloc_checker.sv
bench/bitmap_first_fit_block_allocator_test.sv
